### rtl/core/row_column_running_stats_macros.svh
// assertion macros for the row/column running statistics block
// used by files that assert; expects a clock named clk and a reset named rst
`ifndef ROW_COLUMN_RUNNING_STATS_MACROS_SVH
`define ROW_COLUMN_RUNNING_STATS_MACROS_SVH

// same-cycle implication, held off during reset
`define RCRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rcrs assertion failed");

// next-cycle implication, held off during reset
`define RCRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcrs assertion failed");

`endif

### rtl/core/rcrs_pkg.sv
// shared types and constants for the row/column running statistics block
// no dependencies
`default_nettype none
package rcrs_pkg;
  localparam int unsigned NW = 11;  // running count and divisor width

  typedef struct packed {
    logic signed [31:0] mean;
    logic [63:0]        sq;
    logic signed [31:0] mn;
    logic signed [31:0] mx;
  } stat_entry_t;

  typedef struct packed {
    logic signed [31:0] x;
    stat_entry_t        entry;
    logic [NW-1:0]      n;
    logic [NW-1:0]      d;
  } welf_req_t;

  typedef struct packed {
    stat_entry_t entry;
    logic [30:0] stdev;
  } welf_res_t;

  localparam logic signed [31:0] MOST_POS = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
  localparam stat_entry_t ENTRY_CLEAR = '{mean: '0, sq: '0, mn: MOST_POS, mx: MOST_NEG};

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;
endpackage
`default_nettype wire

### rtl/core/rcrs_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on nothing
`default_nettype none
module rcrs_div #(
  parameter int W  = 32,
  parameter int DW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [W-1:0]  dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [W-1:0]       quotient
);
  localparam int CW = $clog2(W);

  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, quotient[W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        dvs      <= divisor;
        rem      <= '0;
        cnt      <= '0;
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= fits ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
        quotient <= {quotient[W-2:0], fits};
        cnt      <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/rcrs_sqrt.sv
// bit-serial integer square root of a 64-bit word, one result bit per cycle
// depends on nothing
`default_nettype none
module rcrs_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic [31:0]      root
);
  logic [63:0] x;
  logic [63:0] r;
  logic [63:0] bitv;
  logic        busy;
  logic [63:0] sum;

  assign sum  = r + bitv;
  assign root = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= radicand;
        r    <= '0;
        bitv <= 64'h4000_0000_0000_0000;
        busy <= 1'b1;
      end else if (busy) begin
        if (x >= sum) begin
          x <= x - sum;
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == 64'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/rcrs_lane.sv
// one welford update lane: mean, sum of squares, min, max and stdev
// depends on rcrs_pkg, rcrs_div, rcrs_sqrt
`default_nettype none
module rcrs_lane (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire rcrs_pkg::welf_req_t req,
  output logic                    done,
  output rcrs_pkg::welf_res_t     res
);
  import rcrs_pkg::*;

  typedef enum logic [3:0] {
    L_IDLE, L_PREP, L_DIV1, L_MPREP, L_MUL, L_ACC, L_D2S, L_DIV2, L_SQS, L_SQRT
  } lstate_t;

  lstate_t     state;
  welf_req_t   rq;
  logic        neg;
  logic [31:0] mag;
  logic signed [31:0] nm;
  logic [63:0] acc;
  logic [63:0] ma;
  logic [31:0] mb;
  logic [4:0]  mcnt;
  logic [63:0] s;

  logic [32:0] diff1;
  logic [32:0] diff2;
  logic [33:0] nm_sum;
  logic [64:0] s_sum;
  logic        div1_done;
  logic [31:0] div1_q;
  logic        div2_done;
  logic [63:0] div2_q;
  logic        sq_done;
  logic [31:0] sq_root;

  assign diff1  = {rq.x[31], rq.x} - {rq.entry.mean[31], rq.entry.mean};
  assign diff2  = {rq.x[31], rq.x} - {nm[31], nm};
  assign nm_sum = neg ? {{2{rq.entry.mean[31]}}, rq.entry.mean} - {2'b0, div1_q}
                      : {{2{rq.entry.mean[31]}}, rq.entry.mean} + {2'b0, div1_q};
  assign s_sum  = {1'b0, rq.entry.sq} + {1'b0, acc};

  rcrs_div #(.W(32), .DW(NW)) u_div1 (
    .clk, .rst, .start(state == L_PREP), .dividend(mag), .divisor(rq.n),
    .done(div1_done), .quotient(div1_q)
  );

  rcrs_div #(.W(64), .DW(NW)) u_div2 (
    .clk, .rst, .start(state == L_D2S), .dividend(s), .divisor(rq.d),
    .done(div2_done), .quotient(div2_q)
  );

  rcrs_sqrt u_sqrt (
    .clk, .rst, .start(state == L_SQS), .radicand(div2_q),
    .done(sq_done), .root(sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            rq    <= req;
            state <= L_PREP;
          end
        end
        L_PREP: begin
          // magnitude of x - mean feeds the divider this cycle
          state <= L_DIV1;
        end
        L_DIV1: begin
          if (div1_done) begin
            nm    <= nm_sum[31:0];
            state <= L_MPREP;
          end
        end
        L_MPREP: begin
          ma    <= {32'd0, mag};
          mb    <= diff2[32] ? 32'(-diff2) : diff2[31:0];
          acc   <= '0;
          mcnt  <= '0;
          state <= L_MUL;
        end
        L_MUL: begin
          if (mb[0]) acc <= acc + ma;
          ma   <= ma << 1;
          mb   <= mb >> 1;
          mcnt <= mcnt + 1'b1;
          if (mcnt == 5'd31) state <= L_ACC;
        end
        L_ACC: begin
          s <= s_sum[64] ? '1 : s_sum[63:0];
          res.entry.mean <= nm;
          res.entry.sq   <= s_sum[64] ? '1 : s_sum[63:0];
          res.entry.mn   <= (rq.x < rq.entry.mn) ? rq.x : rq.entry.mn;
          res.entry.mx   <= (rq.x > rq.entry.mx) ? rq.x : rq.entry.mx;
          state <= L_D2S;
        end
        L_D2S: state <= L_DIV2;
        L_DIV2: if (div2_done) state <= L_SQS;
        L_SQS: state <= L_SQRT;
        L_SQRT: begin
          if (sq_done) begin
            if (rq.d == '0)       res.stdev <= '0;
            else if (sq_root[31]) res.stdev <= '1;
            else                  res.stdev <= sq_root[30:0];
            done  <= 1'b1;
            state <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  // sign and magnitude of x - mean, held while the item is in the lane
  assign neg = diff1[32];
  assign mag = diff1[32] ? 32'(-diff1) : diff1[31:0];
endmodule
`default_nettype wire

### rtl/core/row_column_running_stats.sv
// top level of the row/column running statistics block
// depends on rcrs_pkg, rcrs_lane and row_column_running_stats_macros.svh
//
//   channel  direction  handshake              word
//   in       input      in_valid / in_ready    operation, indexes, sample, missing flag
//   out      output     out_valid / out_ready  row and column mean, stdev, min, max
//   cfg      input      cfg_write_en           cols_in_use, no wait
//
// a present cell runs, per lane, a 32-step mean divider, a 32-step shift-add
//   multiplier, a 64-step divider and a 32-step square root in turn; its result
//   word then waits for a free output register
// reset and a clear word start a sweep over max(MAX_ROWS, MAX_COLS) addresses
//   that rewrites both stores; no word is taken during the sweep
// missing or out-of-range cells are taken and give no word
// the next word is taken while a finished result waits on out_ready
`default_nettype none
`include "row_column_running_stats_macros.svh"
module row_column_running_stats #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write_en,
  input  wire logic [10:0]        cfg_write_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               operation,
  input  wire logic [9:0]         row_index,
  input  wire logic [9:0]         column_index,
  input  wire logic signed [31:0] sample_value,
  input  wire logic               cell_missing,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      row_mean,
  output logic [30:0]             row_stdev,
  output logic signed [31:0]      row_minimum,
  output logic signed [31:0]      row_maximum,
  output logic signed [31:0]      col_mean,
  output logic [30:0]             col_stdev,
  output logic signed [31:0]      col_minimum,
  output logic signed [31:0]      col_maximum
);
  import rcrs_pkg::*;

  localparam int RAW   = $clog2(MAX_ROWS);
  localparam int CAW   = $clog2(MAX_COLS);
  localparam int CLR_N = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int KW    = $clog2(CLR_N);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_START, S_RUN, S_WRITE
  } state_t;

  state_t state;

  // statistics stores, one entry per row and per column
  stat_entry_t row_mem [MAX_ROWS];
  stat_entry_t col_mem [MAX_COLS];
  stat_entry_t row_rd;
  stat_entry_t col_rd;

  logic [KW-1:0]      clr_cnt;
  logic [NW-1:0]      cols_in_use;
  logic [RAW-1:0]     row_addr;
  logic [CAW-1:0]     col_addr;
  logic [9:0]         row_idx;
  logic [9:0]         col_idx;
  logic signed [31:0] x_r;

  logic [16:0]    row_ext;
  logic [16:0]    col_ext;
  logic [16:0]    clr_ext;
  logic           in_range;
  logic           accept;
  logic           lane_start;
  welf_req_t      row_req;
  welf_req_t      col_req;
  logic           row_done;
  logic           col_done;
  welf_res_t      row_res;
  welf_res_t      col_res;
  logic           out_free;

  assign row_ext  = 17'(row_index);
  assign col_ext  = 17'(column_index);
  assign clr_ext  = 17'(clr_cnt);
  assign in_range = (row_ext < 17'(MAX_ROWS)) && (col_ext < 17'(MAX_COLS));
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign lane_start = (state == S_START);

  // row divisor is cols_in_use - 1, column divisor is the row index
  always_comb begin
    row_req.x     = x_r;
    row_req.entry = row_rd;
    row_req.n     = NW'(col_idx) + 1'b1;
    row_req.d     = (cols_in_use == '0) ? '0 : cols_in_use - 1'b1;
    col_req.x     = x_r;
    col_req.entry = col_rd;
    col_req.n     = NW'(row_idx) + 1'b1;
    col_req.d     = NW'(row_idx);
  end

  rcrs_lane u_row_lane (
    .clk, .rst, .start(lane_start), .req(row_req), .done(row_done), .res(row_res)
  );

  rcrs_lane u_col_lane (
    .clk, .rst, .start(lane_start), .req(col_req), .done(col_done), .res(col_res)
  );

  // config register, written any time
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= NW'(1024);
    end else if (cfg_write_en) begin
      cols_in_use <= cfg_write_data;
    end
  end

  // control and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == KW'(CLR_N - 1)) begin
            clr_cnt <= '0;
            state   <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            row_idx  <= row_index;
            col_idx  <= column_index;
            x_r      <= sample_value;
            row_addr <= row_ext[RAW-1:0];
            col_addr <= col_ext[CAW-1:0];
            priority if (operation == OP_CLEAR) state <= S_CLEAR;
            else if (!cell_missing && in_range)  state <= S_READ;
            else                                 state <= S_IDLE;
          end
        end
        S_READ:  state <= S_START;
        S_START: state <= S_RUN;
        S_RUN:   if (row_done) state <= S_WRITE;
        S_WRITE: begin
          // hold until the previous word has left the output register
          if (out_free) begin
            out_valid   <= 1'b1;
            row_mean    <= row_res.entry.mean;
            row_stdev   <= row_res.stdev;
            row_minimum <= row_res.entry.mn;
            row_maximum <= row_res.entry.mx;
            col_mean    <= col_res.entry.mean;
            col_stdev   <= col_res.stdev;
            col_minimum <= col_res.entry.mn;
            col_maximum <= col_res.entry.mx;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // store ports: sweep writes during clear, read once and write once per cell
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      if (clr_ext < 17'(MAX_ROWS)) row_mem[clr_ext[RAW-1:0]] <= ENTRY_CLEAR;
    end else if (state == S_WRITE && out_free) begin
      row_mem[row_addr] <= row_res.entry;
    end
    if (state == S_READ) row_rd <= row_mem[row_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      if (clr_ext < 17'(MAX_COLS)) col_mem[clr_ext[CAW-1:0]] <= ENTRY_CLEAR;
    end else if (state == S_WRITE && out_free) begin
      col_mem[col_addr] <= col_res.entry;
    end
    if (state == S_READ) col_rd <= col_mem[col_addr];
  end

  // both lanes run the same fixed schedule
  `RCRS_ASSERT_NOW(a_lanes_in_step, row_done, col_done)
  // a finished item always leaves through the output register
  `RCRS_ASSERT_NEXT(a_write_loads_out, (state == S_WRITE) && out_free, out_valid)
  // lane completion moves straight to the store write
  `RCRS_ASSERT_NEXT(a_run_to_write, (state == S_RUN) && row_done, state == S_WRITE)
endmodule
`default_nettype wire
